FILE: src/awmd_pkg.sv
package awmd_pkg;

  localparam int ACC_W          = 16;
  localparam int DZ_W           = ACC_W + 1;
  localparam int MAG_W          = 17;
  localparam int SQ_W           = 2 * MAG_W;
  localparam int ROOT_STEPS     = SQ_W / 2;
  localparam int ROOT_REM_W     = MAG_W + 3;
  localparam int LIMIT_W        = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 17;
  localparam int WINDOW_LEN_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FAST_COUNT = 3'd5;

  localparam logic signed [ACC_W-1:0] GRAVITY_OFFSET_RST = 16'sd4096;
  localparam logic [MAG_W-1:0]        NORMAL_LOW_RST     = 17'd532;
  localparam logic [MAG_W-1:0]        FAST_LOW_RST       = 17'd1638;
  localparam logic [MAG_W-1:0]        SPIKE_LOW_RST      = 17'd3277;
  localparam logic [LIMIT_W-1:0]      MIN_RUN_RST        = 5'd5;
  localparam logic [LIMIT_W-1:0]      MIN_FAST_COUNT_RST = 5'd4;

  typedef struct packed {
    logic                    action;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [MAG_W-1:0] window_mean;
    logic             moving;
  } out_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] gravity_offset;
    logic [MAG_W-1:0]        normal_low;
    logic [MAG_W-1:0]        fast_low;
    logic [MAG_W-1:0]        spike_low;
    logic [LIMIT_W-1:0]      min_run;
    logic [LIMIT_W-1:0]      min_fast_count;
  } cfg_t;

  // classified work item passed from front to back
  typedef struct packed {
    logic                    clear;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [DZ_W-1:0]  dz;
  } qent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_WRITE,
    ST_WALK,
    ST_DIVIDE,
    ST_DONE
  } back_state_t;

endpackage

FILE: src/awmd_front.sv
module awmd_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  awmd_pkg::in_item_t            in_data,
  input  logic signed [awmd_pkg::ACC_W-1:0] gravity_offset,
  output logic                          push_valid,
  input  logic                          push_ready,
  output awmd_pkg::qent_t               push_data
);

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_data.clear = in_data.action;
    push_data.x     = in_data.accel_x;
    push_data.y     = in_data.accel_y;
    // gravity removal, one bit wider so it never wraps
    push_data.dz    = {in_data.accel_z[awmd_pkg::ACC_W-1], in_data.accel_z}
                    - {gravity_offset[awmd_pkg::ACC_W-1], gravity_offset};
  end

endmodule

FILE: src/awmd_fifo.sv
module awmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  awmd_pkg::qent_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output awmd_pkg::qent_t pop_data
);

  localparam int DEPTH = awmd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  awmd_pkg::qent_t  entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/awmd_back.sv
module awmd_back #(
  parameter int WINDOW_LEN = awmd_pkg::WINDOW_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  awmd_pkg::cfg_t      cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  awmd_pkg::qent_t     pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output awmd_pkg::out_item_t out_data
);

  localparam int MAG_W    = awmd_pkg::MAG_W;
  localparam int SQ_W     = awmd_pkg::SQ_W;
  localparam int RR_W     = awmd_pkg::ROOT_REM_W;
  localparam int DZ_W     = awmd_pkg::DZ_W;
  localparam int ADDR_W   = $clog2(WINDOW_LEN);
  localparam int CNT_W    = $clog2(WINDOW_LEN + 1);
  localparam int LOG2_LEN = $clog2(WINDOW_LEN);
  localparam int SUM_W    = MAG_W + LOG2_LEN;
  localparam int REM_W    = LOG2_LEN + 1;
  localparam int STEP_LIM = (SUM_W > WINDOW_LEN) ? SUM_W : WINDOW_LEN;
  localparam int STEP_W   = $clog2(STEP_LIM + 1);
  localparam int CMP_W    = (CNT_W > awmd_pkg::LIMIT_W) ? CNT_W : awmd_pkg::LIMIT_W;
  localparam bit IS_POW2  = ((WINDOW_LEN & (WINDOW_LEN - 1)) == 0);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_LEN - 1);

  awmd_pkg::back_state_t state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  awmd_pkg::qent_t       item_r, item_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [RR_W-1:0]       rem_r, rem_nxt;
  logic [MAG_W-1:0]      root_r, root_nxt;
  logic [ADDR_W-1:0]     slot_r, slot_nxt;
  logic [WINDOW_LEN-1:0] valid_r, valid_nxt;
  logic [ADDR_W-1:0]     rp_r, rp_nxt;
  logic [MAG_W-1:0]      cur_r, cur_nxt;
  logic [MAG_W-1:0]      prv_r, prv_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      run_r, run_nxt;
  logic [CNT_W-1:0]      best_r, best_nxt;
  logic [CNT_W-1:0]      fast_r, fast_nxt;
  logic                  spike_r, spike_nxt;
  logic [REM_W-1:0]      drem_r, drem_nxt;
  awmd_pkg::out_item_t   out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [MAG_W-1:0]      mem [WINDOW_LEN];
  logic [MAG_W-1:0]      rd_data_r;
  logic                  rd_ok_r;
  logic                  mem_we;

  logic signed [DZ_W-1:0]   mul_op;
  logic signed [SQ_W-1:0]   mul_prod;
  logic [RR_W-1:0]          rem_sh, trial;
  logic [MAG_W-1:0]         walk_d;
  logic                     d_nrm, d_fst, c_nrm, c_fst, c_spk;
  logic [CNT_W-1:0]         run_inc;
  logic [REM_W-1:0]         div_t;
  logic [SUM_W-1:0]         quo;
  logic                     moving;

  assign pop_ready = (state_r == awmd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // shared squarer: x, y, then dz
  always_comb begin
    case (step_r)
      STEP_W'(0): mul_op = {item_r.x[awmd_pkg::ACC_W-1], item_r.x};
      STEP_W'(1): mul_op = {item_r.y[awmd_pkg::ACC_W-1], item_r.y};
      default:    mul_op = item_r.dz;
    endcase
  end
  assign mul_prod = mul_op * mul_op;

  // one root digit per cycle
  assign rem_sh = {rem_r[RR_W-3:0], sq_r[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  // window entry arriving from memory, and the one held for the spike test
  assign walk_d  = rd_ok_r ? rd_data_r : '0;
  assign d_nrm   = (walk_d >= cfg.normal_low) && (walk_d <= cfg.fast_low);
  assign d_fst   = (walk_d > cfg.fast_low) && (walk_d <= cfg.spike_low);
  assign c_nrm   = (cur_r >= cfg.normal_low) && (cur_r <= cfg.fast_low);
  assign c_fst   = (cur_r > cfg.fast_low) && (cur_r <= cfg.spike_low);
  assign c_spk   = !c_nrm && !c_fst && (cur_r > cfg.spike_low)
                && ({1'b0, cur_r} > {prv_r, 1'b0})
                && ({1'b0, cur_r} > {walk_d, 1'b0});
  assign run_inc = run_r + CNT_W'(1);

  assign div_t = {drem_r[REM_W-2:0], sum_r[SUM_W-1]};
  assign quo   = IS_POW2 ? (sum_r >> LOG2_LEN) : sum_r;

  assign moving = !item_r.clear && !spike_r
               && ((CMP_W'(best_r) >= CMP_W'(cfg.min_run))
               ||  (CMP_W'(fast_r) >= CMP_W'(cfg.min_fast_count)));

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    item_nxt      = item_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    slot_nxt      = slot_r;
    valid_nxt     = valid_r;
    rp_nxt        = rp_r;
    cur_nxt       = cur_r;
    prv_nxt       = prv_r;
    sum_nxt       = sum_r;
    run_nxt       = run_r;
    best_nxt      = best_r;
    fast_nxt      = fast_r;
    spike_nxt     = spike_r;
    drem_nxt      = drem_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      awmd_pkg::ST_IDLE: begin
        if (pop_valid) begin
          item_nxt = pop_data;
          step_nxt = '0;
          if (pop_data.clear) begin
            valid_nxt = '0;
            slot_nxt  = '0;
            root_nxt  = '0;
            sum_nxt   = '0;
            state_nxt = awmd_pkg::ST_DONE;
          end else begin
            sq_nxt    = '0;
            rem_nxt   = '0;
            root_nxt  = '0;
            state_nxt = awmd_pkg::ST_SQUARE;
          end
        end
      end

      awmd_pkg::ST_SQUARE: begin
        sq_nxt   = sq_r + $unsigned(mul_prod);
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(2)) begin
          step_nxt  = '0;
          state_nxt = awmd_pkg::ST_ROOT;
        end
      end

      awmd_pkg::ST_ROOT: begin
        sq_nxt = sq_r << 2;
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[MAG_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(awmd_pkg::ROOT_STEPS - 1)) begin
          state_nxt = awmd_pkg::ST_WRITE;
        end
      end

      awmd_pkg::ST_WRITE: begin
        mem_we            = 1'b1;
        valid_nxt[slot_r] = 1'b1;
        slot_nxt          = (slot_r == LAST_SLOT) ? '0 : slot_r + ADDR_W'(1);
        // oldest entry sits right after the one just written
        rp_nxt            = slot_nxt;
        step_nxt          = '0;
        sum_nxt           = '0;
        run_nxt           = '0;
        best_nxt          = '0;
        fast_nxt          = '0;
        spike_nxt         = 1'b0;
        drem_nxt          = '0;
        state_nxt         = awmd_pkg::ST_WALK;
      end

      awmd_pkg::ST_WALK: begin
        rp_nxt   = (rp_r == LAST_SLOT) ? '0 : rp_r + ADDR_W'(1);
        step_nxt = step_r + STEP_W'(1);
        if (step_r != '0) begin
          sum_nxt = sum_r + SUM_W'(walk_d);
          if (d_nrm) begin
            run_nxt = run_inc;
            if (run_inc > best_r) begin
              best_nxt = run_inc;
            end
          end else if (d_fst) begin
            fast_nxt = fast_r + CNT_W'(1);
          end
          if (walk_d < cfg.normal_low) begin
            run_nxt = '0;
          end
          // held entry has both neighbors once the third entry arrives
          if (step_r >= STEP_W'(3) && c_spk) begin
            spike_nxt = 1'b1;
          end
          prv_nxt = cur_r;
          cur_nxt = walk_d;
        end
        if (step_r == STEP_W'(WINDOW_LEN)) begin
          step_nxt  = '0;
          state_nxt = IS_POW2 ? awmd_pkg::ST_DONE : awmd_pkg::ST_DIVIDE;
        end
      end

      awmd_pkg::ST_DIVIDE: begin
        // restoring division, quotient bits shift into the sum register
        if (div_t >= REM_W'(WINDOW_LEN)) begin
          drem_nxt = div_t - REM_W'(WINDOW_LEN);
          sum_nxt  = {sum_r[SUM_W-2:0], 1'b1};
        end else begin
          drem_nxt = div_t;
          sum_nxt  = {sum_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = awmd_pkg::ST_DONE;
        end
      end

      awmd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.magnitude   = root_r;
          out_nxt.window_mean = quo[MAG_W-1:0];
          out_nxt.moving      = moving;
          out_valid_nxt       = 1'b1;
          state_nxt           = awmd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = awmd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= awmd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      slot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      slot_r      <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    item_r  <= item_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    rp_r    <= rp_nxt;
    cur_r   <= cur_nxt;
    prv_r   <= prv_nxt;
    sum_r   <= sum_nxt;
    run_r   <= run_nxt;
    best_r  <= best_nxt;
    fast_r  <= fast_nxt;
    spike_r <= spike_nxt;
    drem_r  <= drem_nxt;
    out_r   <= out_nxt;
  end

  // window store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= root_r;
    end
    rd_data_r <= mem[rp_r];
    rd_ok_r   <= valid_r[rp_r];
  end

endmodule

FILE: src/accel_window_motion_detector_core.sv
// a sample runs through the square, root, write, walk and done states when WINDOW_LEN is a
//   power of two, with SUM_W = 17 + clog2(WINDOW_LEN) divide steps before done otherwise
// the back end holds one sample at a time and takes the next only when idle, bounded by the
//   17-step square root and the one-entry-per-cycle walk of the window memory read port
// a clear transaction goes straight to the result state; the queue ahead holds two items
// reset: synchronous, clears window valid bits, write slot, queue and handshakes at once
module accel_window_motion_detector_core #(
  parameter int WINDOW_LEN = awmd_pkg::WINDOW_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  awmd_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output awmd_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [awmd_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [awmd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  awmd_pkg::cfg_t  cfg_r, cfg_nxt;
  awmd_pkg::qent_t push_data, pop_data;
  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        awmd_pkg::REG_GRAVITY_OFFSET: cfg_nxt.gravity_offset = cfg_wdata[awmd_pkg::ACC_W-1:0];
        awmd_pkg::REG_NORMAL_LOW:     cfg_nxt.normal_low     = cfg_wdata[awmd_pkg::MAG_W-1:0];
        awmd_pkg::REG_FAST_LOW:       cfg_nxt.fast_low       = cfg_wdata[awmd_pkg::MAG_W-1:0];
        awmd_pkg::REG_SPIKE_LOW:      cfg_nxt.spike_low      = cfg_wdata[awmd_pkg::MAG_W-1:0];
        awmd_pkg::REG_MIN_RUN:        cfg_nxt.min_run        = cfg_wdata[awmd_pkg::LIMIT_W-1:0];
        awmd_pkg::REG_MIN_FAST_COUNT: cfg_nxt.min_fast_count = cfg_wdata[awmd_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_offset <= awmd_pkg::GRAVITY_OFFSET_RST;
      cfg_r.normal_low     <= awmd_pkg::NORMAL_LOW_RST;
      cfg_r.fast_low       <= awmd_pkg::FAST_LOW_RST;
      cfg_r.spike_low      <= awmd_pkg::SPIKE_LOW_RST;
      cfg_r.min_run        <= awmd_pkg::MIN_RUN_RST;
      cfg_r.min_fast_count <= awmd_pkg::MIN_FAST_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  awmd_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .gravity_offset (cfg_r.gravity_offset),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  awmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  awmd_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/awmd_checker.sv
module awmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input awmd_pkg::out_item_t out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // a result only goes away after it was taken
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(out_valid) |-> $past(out_ready))
    else $error("result withdrawn without transaction");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // queue is empty after reset, so input is ready at once
  a_rst_ready: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind accel_window_motion_detector_core awmd_checker u_awmd_checker (.*);

FILE: tb/sv/awmd_motion_checker.sv
module awmd_motion_checker
  import awmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    pending,
  output int                    samples_seen,
  output int                    clears_seen,
  output int                    results_seen,
  output int                    moving_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = WINDOW_LEN_DEF;

  logic signed [ACC_W-1:0] grav;
  logic [MAG_W-1:0]        band_normal;
  logic [MAG_W-1:0]        band_fast;
  logic [MAG_W-1:0]        band_spike;
  logic [LIMIT_W-1:0]      need_run;
  logic [LIMIT_W-1:0]      need_fast;

  logic [MAG_W-1:0] mag_win [WIN];
  int unsigned      slot;
  out_item_t        expected_motion_q [$];

  function automatic logic [MAG_W-1:0] floor_root(longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = n;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return MAG_W'(root);
  endfunction

  // updates the window copy and returns the result this transaction should produce
  function automatic out_item_t predict_motion(in_item_t it);
    out_item_t       res;
    longint signed   x;
    longint signed   y;
    longint signed   dz;
    longint unsigned sq;
    logic [MAG_W-1:0] mag;
    int unsigned     v;
    int unsigned     prv;
    int unsigned     nxt;
    int unsigned     total;
    int unsigned     run;
    int unsigned     longest;
    int unsigned     fast_n;
    int unsigned     p;
    logic            spike;
    res = '0;
    if (it.action) begin
      for (p = 0; p < WIN; p++) mag_win[p] = '0;
      slot = 0;
      return res;
    end
    x  = longint'($signed(it.accel_x));
    y  = longint'($signed(it.accel_y));
    dz = longint'($signed(it.accel_z)) - longint'(grav);
    sq = longint'(x * x + y * y + dz * dz);
    mag = floor_root(sq);
    mag_win[slot] = mag;
    slot = (slot + 1) % WIN;

    total   = 0;
    run     = 0;
    longest = 0;
    fast_n  = 0;
    spike   = 1'b0;
    // oldest entry sits at the slot about to be overwritten
    for (p = 0; p < WIN; p++) begin
      v = mag_win[(slot + p) % WIN];
      total += v;
      if (v >= band_normal && v <= band_fast) begin
        run++;
        if (run > longest) longest = run;
      end else if (v > band_fast && v <= band_spike) begin
        fast_n++;
      end else if (v > band_spike && p > 0 && p < WIN - 1) begin
        prv = mag_win[(slot + p - 1) % WIN];
        nxt = mag_win[(slot + p + 1) % WIN];
        if (v > 2 * prv && v > 2 * nxt) spike = 1'b1;
      end
      if (v < band_normal) run = 0;
    end
    res.magnitude   = mag;
    res.window_mean = MAG_W'(total / WIN);
    res.moving      = (longest >= need_run || fast_n >= need_fast) && !spike;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      grav        = GRAVITY_OFFSET_RST;
      band_normal = NORMAL_LOW_RST;
      band_fast   = FAST_LOW_RST;
      band_spike  = SPIKE_LOW_RST;
      need_run    = MIN_RUN_RST;
      need_fast   = MIN_FAST_COUNT_RST;
      for (int i = 0; i < WIN; i++) mag_win[i] = '0;
      slot = 0;
      expected_motion_q.delete();
      pending      = 0;
      mismatches   = 0;
      samples_seen = 0;
      clears_seen  = 0;
      results_seen = 0;
      moving_seen  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRAVITY_OFFSET: grav        = cfg_wdata[ACC_W-1:0];
          REG_NORMAL_LOW:     band_normal = cfg_wdata[MAG_W-1:0];
          REG_FAST_LOW:       band_fast   = cfg_wdata[MAG_W-1:0];
          REG_SPIKE_LOW:      band_spike  = cfg_wdata[MAG_W-1:0];
          REG_MIN_RUN:        need_run    = cfg_wdata[LIMIT_W-1:0];
          REG_MIN_FAST_COUNT: need_fast   = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.moving) moving_seen++;
        if (expected_motion_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d arrived with nothing outstanding (mag %0d mean %0d mov %0b)",
                     $realtime, results_seen, out_data.magnitude, out_data.window_mean,
                     out_data.moving);
        end else begin
          want = expected_motion_q.pop_front();
          pending--;
          if (out_data.magnitude !== want.magnitude ||
              out_data.window_mean !== want.window_mean ||
              out_data.moving !== want.moving) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: magnitude exp %0d got %0d, mean exp %0d got %0d, %s",
                       $realtime, results_seen, want.magnitude, out_data.magnitude,
                       want.window_mean, out_data.window_mean,
                       $sformatf("moving exp %0b got %0b", want.moving, out_data.moving));
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_data.action) clears_seen++;
        else samples_seen++;
        expected_motion_q.push_back(predict_motion(in_data));
        pending++;
      end
    end
  end

endmodule

FILE: tb/sv/accel_window_motion_detector_core_test.sv
module accel_window_motion_detector_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import awmd_pkg::*;

  // the limit covers the slowest correct transaction (item, latency, longest receiver
  // stall, longest sender gap) many times over
  localparam int IDLE_LIMIT     = 4000;
  localparam int PHASE_ITEMS    = 200;
  localparam int PHASES         = 8;
  localparam int DRAIN_CYCLES   = 60;

  typedef enum int {RX_OPEN, RX_FLICKER, RX_BLOCKED} rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int samples_seen;
  int clears_seen;
  int results_seen;
  int moving_seen;

  // register values as last written, used only to steer stimulus into the bands
  int          steer_g  = 4096;
  int unsigned steer_nl = 532;
  int unsigned steer_fl = 1638;
  int unsigned steer_sl = 3277;

  int       burst_left  = 0;
  int       quiet_count = 0;
  int       rx_left     = 0;
  rx_mode_t rx_mode     = RX_OPEN;

  always #5 clk = ~clk;

  accel_window_motion_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  awmd_motion_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .samples_seen (samples_seen),
    .clears_seen  (clears_seen),
    .results_seen (results_seen),
    .moving_seen  (moving_seen)
  );

  // receiver: long open stretches, flickering ready, and hard stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        case (rx_mode)
          RX_OPEN:    rx_left = $urandom_range(20, 200);
          RX_FLICKER: rx_left = $urandom_range(10, 100);
          default:    rx_left = $urandom_range(1, 80);
        endcase
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_FLICKER: out_ready <= 1'($urandom_range(0, 1));
        default:    out_ready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic in_item_t build(bit act, int x, int y, int z);
    in_item_t it;
    it.action  = act;
    it.accel_x = 16'(x);
    it.accel_y = 16'(y);
    it.accel_z = 16'(z);
    return it;
  endfunction

  // sample whose magnitude lands close to target under the current gravity offset
  function automatic in_item_t shaped_sample(int unsigned target);
    in_item_t    it;
    int          share;
    int          zv;
    int unsigned lane;
    bit          flip;
    it   = '0;
    lane = $urandom_range(0, 2);
    flip = 1'($urandom_range(0, 1));
    if (target > 56000) target = 56000;
    if (target > 32767) begin
      share = int'(target) * 577 / 1000;
      it.accel_x = 16'(flip ? -share : share);
      it.accel_y = 16'(share);
      lane = 2;
    end else begin
      share = int'(target);
    end
    it.accel_z = 16'(steer_g);
    if (lane == 0 && target <= 32767) begin
      it.accel_x = 16'(flip ? -share : share);
    end else if (lane == 1 && target <= 32767) begin
      it.accel_y = 16'(flip ? -share : share);
    end else begin
      zv = steer_g + share;
      if (zv > 32767) zv = steer_g - share;
      it.accel_z = 16'(zv);
    end
    return it;
  endfunction

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    if (hi > 60000) hi = 60000;
    if (lo >= hi) return lo;
    return $urandom_range(hi, lo);
  endfunction

  task automatic send(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic configure(int g, int unsigned nl, int unsigned fl, int unsigned sl,
                           int unsigned mr, int unsigned mf);
    write_reg(REG_GRAVITY_OFFSET, CFG_DATA_W'(16'(g)));
    write_reg(REG_NORMAL_LOW,     CFG_DATA_W'(nl));
    write_reg(REG_FAST_LOW,       CFG_DATA_W'(fl));
    write_reg(REG_SPIKE_LOW,      CFG_DATA_W'(sl));
    write_reg(REG_MIN_RUN,        CFG_DATA_W'(mr));
    write_reg(REG_MIN_FAST_COUNT, CFG_DATA_W'(mf));
    cfg_we <= 1'b0;
    @(posedge clk);
    steer_g  = g;
    steer_nl = nl;
    steer_fl = fl;
    steer_sl = sl;
  endtask

  task automatic directed_part();
    send(build(1, 32767, -32768, 12345));   // clear of an empty window, junk axes
    send(build(0, -32768, -32768, -32768));
    send(build(0, 32767, 32767, 32767));
    send(build(0, 0, 0, 4096));             // gravity only, zero magnitude
    send(build(0, -1, -1, -1));
    repeat (6) send(build(0, 1000, 0, 4096));
    send(build(0, 100, 0, 4096));           // below band breaks the run
    repeat (4) send(build(0, 0, -2000, 4096));
    send(build(0, 100, 0, 4096));
    send(build(0, 9000, 0, 4096));          // interior spike
    send(build(0, 100, 0, 4096));
    send(build(0, 4000, 0, 4096));
    send(build(0, 8000, 0, 4096));          // exactly twice a neighbor, no spike
    send(build(0, 4000, 0, 4096));
    send(build(1, -1, -1, -1));
    send(build(0, 0, 0, 4096 + 9000));      // large value at the newest slot only
    send(build(0, 531, 0, 4096));
    send(build(0, 532, 0, 4096));
    send(build(0, 1638, 0, 4096));
    send(build(0, 3277, 0, 4096));
    send(build(0, 3278, 0, 4096));
  endtask

  task automatic random_part(int n);
    int          count;
    int          kind;
    int          len;
    int unsigned lo_t;
    count = 0;
    while (count < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        len = $urandom_range(1, 18);
        repeat (len) send(shaped_sample(pick(steer_nl, steer_fl)));
        count += len;
      end else if (kind < 50) begin
        len = $urandom_range(1, 8);
        repeat (len) send(shaped_sample(pick(steer_fl + 1, steer_sl)));
        count += len;
      end else if (kind < 60) begin
        lo_t = pick(0, steer_sl / 4);
        send(shaped_sample(lo_t));
        send(shaped_sample(pick(steer_sl + 1, steer_sl + 20001)));
        send(shaped_sample(pick(0, steer_sl / 4)));
        count += 3;
      end else if (kind < 75) begin
        len = $urandom_range(1, 4);
        repeat (len) send(shaped_sample(pick(0, (steer_nl == 0) ? 0 : steer_nl - 1)));
        count += len;
      end else if (kind < 95) begin
        send(build(0, int'($urandom), int'($urandom), int'($urandom)));
        count++;
      end else begin
        send(build(1, int'($urandom), int'($urandom), int'($urandom)));
        count++;
      end
    end
  endtask

  initial begin
    int unsigned nl;
    int unsigned fl;
    int unsigned sl;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();
    random_part(PHASE_ITEMS);
    for (int ph = 1; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: configure(-32768, 0, 131071, 131071, 16, 16);
        2: configure(32767, 131071, 0, 0, 0, 0);   // inverted bands, zero limits
        3: configure(0, 100, 400, 800, 1, 1);
        5: configure(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 131071),
                     $urandom_range(0, 131071), $urandom_range(0, 131071),
                     $urandom_range(0, 16), $urandom_range(0, 16));
        7: configure(-4096, 1, 2, 3, 2, 16);
        default: begin
          nl = $urandom_range(0, 3000);
          fl = nl + $urandom_range(0, 3000);
          sl = fl + $urandom_range(0, 6000);
          configure(int'($urandom_range(0, 16384)) - 8192, nl, fl, sl,
                    $urandom_range(0, 16), $urandom_range(0, 16));
        end
      endcase
      random_part(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d window clears over %0d register settings",
             samples_seen, clears_seen, PHASES);
    $display("%0d results checked, %0d with motion flagged, %0d mismatches",
             results_seen, moving_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: accel_window_motion_detector_core.f
src/awmd_pkg.sv
src/awmd_front.sv
src/awmd_fifo.sv
src/awmd_back.sv
src/accel_window_motion_detector_core.sv
src/awmd_checker.sv
tb/sv/awmd_motion_checker.sv
tb/sv/accel_window_motion_detector_core_test.sv
